>>> rtl/tlbpt_pkg.sv
// tlbpt_pkg: shared types and constants of the page table translator
// no dependencies
package tlbpt_pkg;
    localparam int VA_WIDTH = 20;
    localparam int PA_WIDTH = 18;
    localparam int EVP_WIDTH = 10;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_PICK  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // broadcast from control to the frame cell chain
    typedef struct packed {
        logic touch;
    } t_cell_ctl;
endpackage

>>> rtl/tlb_page_table_translator_unit.sv
// tlb_page_table_translator_unit: tlb, page table memory and frame cell chain
// depends on tlbpt_pkg and tlbpt_frame_cell
//
// channel  | signals                            | dir
// request  | i_start, o_busy, i_virtual_address | in
// result   | o_valid + five result fields       | out
// config   | i_cfg_valid, o_cfg_ready, i_cfg_data | in
// an item passes the states idle, look, pick and done; the next is accepted only back in idle
// an lru eviction adds the scan state between pick and done to find the frame holding the oldest rank
// page table read is one registered memory port
// reset clears valid bits by a sweep over all PAGE_COUNT entries, busy meanwhile
// the receiver cannot stall: each result strobes for one cycle
module tlb_page_table_translator_unit #(
    parameter int TLB_ENTRIES  = 16,
    parameter int PAGE_COUNT   = 1024,
    parameter int FRAME_COUNT  = 256,
    parameter int OFFSET_WIDTH = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [tlbpt_pkg::VA_WIDTH-1:0] i_virtual_address,
    output logic        o_valid,
    output logic [tlbpt_pkg::PA_WIDTH-1:0] o_physical_address,
    output logic        o_tlb_hit,
    output logic        o_page_fault,
    output logic        o_evict_valid,
    output logic [tlbpt_pkg::EVP_WIDTH-1:0] o_evicted_page,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PW = $clog2(PAGE_COUNT);
    localparam int FW = $clog2(FRAME_COUNT);

    tlbpt_pkg::t_state r_state, n_state;
    logic          r_mode;
    logic          r_clr;
    logic [PW-1:0] r_clr_idx;

    logic [PW-1:0]   r_tlb_page [TLB_ENTRIES];
    logic [FW-1:0]   r_tlb_frame[TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_valid, n_tlb_valid;
    logic [TW-1:0]   r_tlb_next;

    logic [FW-1:0]   r_pt_frame [PAGE_COUNT];
    logic            r_pt_valid [PAGE_COUNT];
    logic [FW-1:0]   r_pt_rd_frame;
    logic            r_pt_rd_valid;

    logic [FW:0]     r_used;
    logic [FW-1:0]   r_fifo;
    logic [PW-1:0]   r_page;
    logic [OFFSET_WIDTH-1:0] r_off;
    logic            r_hit, r_fault, r_evict;
    logic [FW-1:0]   r_frame;
    logic [PW-1:0]   r_evp;
    logic [FW:0]     r_limit;

    logic            hit;
    logic [FW-1:0]   hit_frame;
    logic [PW-1:0]   page_now;
    logic            pt_we;
    logic [PW-1:0]   pt_wa;
    logic            pt_wv;
    logic            fault_now;
    logic [FW-1:0]   new_frame;
    logic [FW-1:0]   pick_frame;
    logic [FW-1:0]   lru_idx;

    always_comb begin
        hit = 1'b0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && r_tlb_page[i] == r_page) begin
                hit = 1'b1;
                hit_frame = r_tlb_frame[i];
            end
        end
    end

    assign page_now = PW'(i_virtual_address[tlbpt_pkg::VA_WIDTH-1:OFFSET_WIDTH]);

    // frame cell chain
    logic [PW-1:0] owner     [FRAME_COUNT];
    logic [FW-1:0] rank      [FRAME_COUNT];
    tlbpt_pkg::t_cell_ctl ctl;
    logic          set_owner;

    for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
        tlbpt_frame_cell #(.FW(FW), .PW(PW)) u_cell (
            .i_clk(i_clk),
            .i_used((FW+1)'(g) < r_used),
            .i_sel(r_frame == FW'(g)),
            .i_set_owner(set_owner), .i_owner(r_page),
            .i_ctl(ctl), .i_limit(r_limit),
            .o_rank(rank[g]), .o_owner(owner[g])
        );
    end

    // used frames hold distinct ranks, so the oldest is the one ranked last
    always_comb begin
        lru_idx = '0;
        for (int g = 0; g < FRAME_COUNT; g++) begin
            if (rank[g] == FW'(FRAME_COUNT - 1)) lru_idx = lru_idx | FW'(g);
        end
    end

    assign ctl.touch = (r_state == tlbpt_pkg::S_DONE);
    assign set_owner = (r_state == tlbpt_pkg::S_DONE) && r_fault;

    assign o_busy = (r_state != tlbpt_pkg::S_IDLE) || r_clr;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlbpt_pkg::S_IDLE: if (i_start && !r_clr) n_state = tlbpt_pkg::S_LOOK;
            tlbpt_pkg::S_LOOK: n_state = tlbpt_pkg::S_PICK;
            tlbpt_pkg::S_PICK: begin
                if (!hit && !r_pt_rd_valid && r_used[FW] && r_mode) begin
                    n_state = tlbpt_pkg::S_SCAN;
                end else begin
                    n_state = tlbpt_pkg::S_DONE;
                end
            end
            tlbpt_pkg::S_SCAN: n_state = tlbpt_pkg::S_DONE;
            tlbpt_pkg::S_DONE: n_state = tlbpt_pkg::S_IDLE;
            default: n_state = tlbpt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        fault_now = !hit && !r_pt_rd_valid;
        if (r_state == tlbpt_pkg::S_SCAN) begin
            new_frame = lru_idx;
        end else if (!r_used[FW]) begin
            new_frame = r_used[FW-1:0];
        end else begin
            new_frame = r_fifo;
        end
        if (hit) begin
            pick_frame = hit_frame;
        end else if (r_pt_rd_valid) begin
            pick_frame = r_pt_rd_frame;
        end else begin
            pick_frame = new_frame;
        end
    end

    always_comb begin
        n_tlb_valid = r_tlb_valid;
        if (r_state == tlbpt_pkg::S_DONE) begin
            if (r_evict) begin
                for (int i = 0; i < TLB_ENTRIES; i++) begin
                    if (r_tlb_page[i] == r_evp) n_tlb_valid[i] = 1'b0;
                end
            end
            if (!r_hit) n_tlb_valid[r_tlb_next] = 1'b1;
        end
    end

    always_comb begin
        pt_we = 1'b0;
        pt_wa = r_page;
        pt_wv = 1'b1;
        if (r_clr) begin
            pt_we = 1'b1;
            pt_wa = r_clr_idx;
            pt_wv = 1'b0;
        end else if (r_state == tlbpt_pkg::S_DONE && r_evict) begin
            pt_we = 1'b1;
            pt_wa = r_evp;
            pt_wv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pt_valid[pt_wa] <= pt_wv;
        end else if (r_state == tlbpt_pkg::S_SCAN ||
                     (r_state == tlbpt_pkg::S_PICK && n_state == tlbpt_pkg::S_DONE
                      && fault_now)) begin
            r_pt_valid[r_page] <= 1'b1;
            r_pt_frame[r_page] <= new_frame;
        end
        if (r_state == tlbpt_pkg::S_LOOK) begin
            r_pt_rd_frame <= r_pt_frame[r_page];
            r_pt_rd_valid <= r_pt_valid[r_page];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlbpt_pkg::S_IDLE;
            r_mode <= 1'b0;
            r_clr <= 1'b1;
            r_clr_idx <= '0;
            r_tlb_valid <= '0;
            r_tlb_next <= '0;
            r_used <= '0;
            r_fifo <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == tlbpt_pkg::S_DONE);
            r_tlb_valid <= n_tlb_valid;
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == PW'(PAGE_COUNT - 1)) r_clr <= 1'b0;
            end
            if (r_state == tlbpt_pkg::S_IDLE && i_start && !r_clr) begin
                r_page <= page_now;
                r_off  <= i_virtual_address[OFFSET_WIDTH-1:0];
            end
            if (r_state == tlbpt_pkg::S_PICK) begin
                r_hit <= hit;
                r_fault <= fault_now;
                r_evict <= fault_now && r_used[FW];
                r_frame <= pick_frame;
                r_evp <= owner[pick_frame];
                if (fault_now && !r_used[FW]) begin
                    r_limit <= {1'b1, {FW{1'b1}}};
                end else begin
                    r_limit <= {1'b0, rank[pick_frame]};
                end
                if (fault_now) begin
                    r_fifo <= r_fifo + 1'b1;
                    if (!r_used[FW]) r_used <= r_used + 1'b1;
                end
            end
            if (r_state == tlbpt_pkg::S_SCAN) begin
                r_frame <= new_frame;
                r_evp <= owner[new_frame];
                r_limit <= {1'b0, FW'(FRAME_COUNT - 1)};
            end
            if (r_state == tlbpt_pkg::S_DONE) begin
                if (!r_hit) begin
                    r_tlb_page[r_tlb_next] <= r_page;
                    r_tlb_frame[r_tlb_next] <= r_frame;
                    r_tlb_next <= (r_tlb_next == TW'(TLB_ENTRIES - 1)) ? '0
                                  : r_tlb_next + 1'b1;
                end
                o_physical_address <= tlbpt_pkg::PA_WIDTH'(
                    {r_frame, r_off} & {(FW + OFFSET_WIDTH){1'b1}});
                o_tlb_hit <= r_hit;
                o_page_fault <= r_fault;
                o_evict_valid <= r_evict;
                o_evicted_page <= r_evict ? tlbpt_pkg::EVP_WIDTH'(r_evp) : '0;
            end
        end
    end

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe repeated");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlbpt_pkg::S_LOOK) |-> $past(i_start)) else $error("lookup without start");
    a_hit_nofault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_tlb_hit && o_page_fault)) else $error("hit and fault");
endmodule

>>> rtl/tlbpt_frame_cell.sv
// tlbpt_frame_cell: one frame of the recency chain, holds rank and owner page
// depends on tlbpt_pkg
module tlbpt_frame_cell #(
    parameter int FW = 8,
    parameter int PW = 10
) (
    input  logic                i_clk,
    input  logic                i_used,
    input  logic                i_sel,
    input  logic                i_set_owner,
    input  logic [PW-1:0]       i_owner,
    input  tlbpt_pkg::t_cell_ctl i_ctl,
    input  logic [FW:0]         i_limit,
    output logic [FW-1:0]       o_rank,
    output logic [PW-1:0]       o_owner
);
    logic [FW-1:0] r_rank;
    logic [PW-1:0] r_owner;

    always_ff @(posedge i_clk) begin
        if (i_set_owner && i_sel) begin
            r_owner <= i_owner;
        end
        if (i_ctl.touch) begin
            if (i_sel) begin
                r_rank <= '0;
            end else if (i_used && ({1'b0, r_rank} < i_limit)) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    assign o_rank  = r_rank;
    assign o_owner = r_owner;
endmodule
